>>> hdl/dox_pkg.sv
// Package: shared types, constants and command/status structs for the DER OID extractor.
package dox_pkg;

  localparam int unsigned MaxNestingDefault = 8;

  localparam logic [7:0] TagSeq = 8'h30;
  localparam logic [7:0] TagOid = 8'h06;

  localparam logic [1:0] StOk          = 2'd0;
  localparam logic [1:0] StInvalid     = 2'd1;
  localparam logic [1:0] StUnsupported = 2'd2;
  localparam logic [1:0] StNotFound    = 2'd3;

  localparam logic [1:0] RegTargetOid     = 2'd0;
  localparam logic [1:0] RegSampleCap     = 2'd1;
  localparam logic [1:0] RegCropFromFront = 2'd2;

  localparam logic [15:0] SampleCapReset = 16'd64;

  typedef enum logic [1:0] {
    CtlIdle,
    CtlClose,
    CtlOut0,
    CtlOut1
  } ctl_state_e;

  typedef struct packed {
    logic       load;    // take a byte into the datapath
    logic       close;   // run one sequence-close check
  } dox_cmd_t;

  typedef struct packed {
    logic need_close;    // close checks still pending
    logic has_sample;    // the accepted byte produced a sample byte
  } dox_sts_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  sbyte;
    logic [15:0] sidx;
    logic [1:0]  status;
    logic        cropped;
    logic        fin;
  } dox_res_t;

  function automatic logic is_searchable(input logic [7:0] t);
    case (t)
      8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h0C, 8'h13, 8'h17: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

>>> hdl/dox_ctrl.sv
// Controller: sequences byte load, sequence-close checks and result delivery.
module dox_ctrl
  import dox_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     in_eos_i,
  input  logic     out_ready_i,
  output logic     out_valid_o,
  output logic     out_sel_o,   // 0 sample result, 1 status result
  output dox_cmd_t cmd_o,
  input  dox_sts_t sts_i
);

  ctl_state_e state_q, state_d;
  logic eos_q, eos_d;

  always_comb begin
    state_d = state_q;
    eos_d   = eos_q;
    case (state_q)
      CtlIdle: begin
        if (in_valid_i) begin
          eos_d   = in_eos_i;
          state_d = CtlClose;
        end
      end
      CtlClose: begin
        if (!sts_i.need_close) begin
          if (sts_i.has_sample)  state_d = CtlOut0;
          else if (eos_q)        state_d = CtlOut1;
          else                   state_d = CtlIdle;
        end
      end
      CtlOut0: begin
        if (out_ready_i) state_d = eos_q ? CtlOut1 : CtlIdle;
      end
      CtlOut1: begin
        if (out_ready_i) state_d = CtlIdle;
      end
      default: state_d = CtlIdle;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    out_sel_o   = 1'b0;
    cmd_o       = '0;
    case (state_q)
      CtlIdle:  begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      CtlClose: cmd_o.close = sts_i.need_close;
      CtlOut0:  out_valid_o = 1'b1;
      CtlOut1:  begin
        out_valid_o = 1'b1;
        out_sel_o   = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CtlIdle;
      eos_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      eos_q   <= eos_d;
    end
  end

endmodule

>>> hdl/dox_dp.sv
// Datapath: DER header/content parsing, sequence end stack, sampling and status.
module dox_dp
  import dox_pkg::*;
#(
  parameter int unsigned MaxNesting = MaxNestingDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic [7:0]  byte_i,
  input  logic        eos_i,
  input  dox_cmd_t    cmd_i,
  output dox_sts_t    sts_o,
  input  logic        out_sel_i,
  input  logic        out_done_i,   // final status transfer completed
  output dox_res_t    res_o
);

  localparam int unsigned DW = $clog2(MaxNesting + 1);
  localparam int unsigned AW = (MaxNesting > 1) ? $clog2(MaxNesting) : 1;
  localparam logic [DW-1:0] MaxD = DW'(MaxNesting);

  typedef enum logic [1:0] {PhTag, PhLen, PhLenx, PhContent} ph_e;

  logic [23:0] target_q;
  logic [15:0] cap_q;
  logic        front_q;

  logic [15:0] pos_q, pos_d;
  logic [16:0] stack_q [MaxNesting];
  logic [DW-1:0] depth_q, depth_d;
  ph_e         ph_q, ph_d;
  logic [7:0]  tag_q, tag_d;
  logic [15:0] len_q, len_d;
  logic [1:0]  lbl_q, lbl_d;
  logic [15:0] cl_q, cl_d;
  logic [23:0] oid_q, oid_d;
  logic        armed_q, armed_d, found_q, found_d, crop_q, crop_d, smp_q, smp_d;
  logic [1:0]  err_q, err_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] lead_q, lead_d, take_q, take_d;
  logic        close_q, close_d;
  logic        hs_q, hs_d;
  logic [7:0]  sb_q, sb_d;
  logic [15:0] si_q, si_d;
  logic        push;
  logic [16:0] push_val;

  // close check on the top of stack
  logic [16:0] top;
  logic [16:0] pos_ext;
  assign top     = stack_q[AW'(depth_q - DW'(1))];
  assign pos_ext = {1'b0, pos_q};

  assign sts_o.need_close = close_q;
  assign sts_o.has_sample = hs_q;

  always_comb begin
    logic [15:0] offset, len_v, rel;
    logic        hdr, obj;
    pos_d = pos_q; depth_d = depth_q; ph_d = ph_q; tag_d = tag_q; len_d = len_q;
    lbl_d = lbl_q; cl_d = cl_q; oid_d = oid_q; armed_d = armed_q; found_d = found_q;
    crop_d = crop_q; smp_d = smp_q; err_d = err_q; cnt_d = cnt_q;
    lead_d = lead_q; take_d = take_q; close_d = 1'b0; hs_d = hs_q;
    sb_d = sb_q; si_d = si_q; push = 1'b0; push_val = pos_ext + 17'(len_q);
    hdr = 1'b0; obj = 1'b0; len_v = len_q; offset = len_q - cl_q; rel = '0;
    if (cmd_i.load) begin
      hs_d = 1'b0;
      if (err_q == StOk) begin
        if (pos_q == 16'hFFFF) begin
          err_d = StInvalid;
        end else if (!(eos_i && ph_q == PhTag && depth_q == '0)) begin
          pos_d = pos_q + 16'd1;
          case (ph_q)
            PhLen: begin
              if (byte_i < 8'd127) begin
                len_v = {8'd0, byte_i}; hdr = 1'b1;
              end else if (byte_i == 8'h80) begin
                len_v = '0; hdr = 1'b1;
              end else if (byte_i == 8'h81 || byte_i == 8'h82) begin
                len_v = '0; lbl_d = byte_i[1:0]; ph_d = PhLenx;
              end else begin
                err_d = StUnsupported;
              end
              len_d = len_v;
            end
            PhLenx: begin
              len_v = {len_q[7:0], byte_i};
              len_d = len_v;
              lbl_d = lbl_q - 2'd1;
              hdr   = (lbl_q == 2'd1);
            end
            PhContent: begin
              if (tag_q == TagOid && offset < 16'd3) oid_d = {oid_q[15:0], byte_i};
              rel = offset - lead_q;
              if (smp_q && offset >= lead_q && rel < take_q) begin
                hs_d = 1'b1; sb_d = byte_i; si_d = cnt_q; cnt_d = cnt_q + 16'd1;
              end
              cl_d = cl_q - 16'd1;
              if (cl_q == 16'd1) begin
                obj = 1'b1;
                if (tag_q == TagOid && len_q >= 16'd3 && oid_d == target_q) armed_d = 1'b1;
              end
            end
            default: begin
              tag_d = byte_i; ph_d = PhLen;
            end
          endcase
          if (hdr) begin
            if (tag_q == TagSeq) begin
              if (depth_q >= MaxD) begin
                err_d = StUnsupported;
              end else begin
                push = 1'b1;
                push_val = {1'b0, pos_d} + 17'(len_v);
                depth_d = depth_q + DW'(1);
                ph_d = PhTag;
                close_d = 1'b1;
              end
            end else begin
              oid_d = '0; cl_d = len_v; smp_d = 1'b0;
              if (is_searchable(tag_q) && armed_q && !found_q) begin
                found_d = 1'b1; armed_d = 1'b0; smp_d = 1'b1;
                lead_d = '0; take_d = len_v;
                if (len_v > cap_q) begin
                  crop_d = 1'b1; take_d = cap_q;
                  if (front_q) lead_d = len_v - cap_q;
                end
              end
              if (len_v == '0) obj = 1'b1;
              else ph_d = PhContent;
            end
          end
          if (obj) begin
            smp_d = 1'b0; ph_d = PhTag; close_d = 1'b1;
          end
        end
      end
    end else if (cmd_i.close) begin
      // one stack level per cycle
      if (depth_q != '0 && err_q == StOk && !(pos_ext + 17'd1 < top)) begin
        if (pos_ext != top) err_d = StInvalid;
        else begin
          depth_d = depth_q - DW'(1);
          close_d = 1'b1;
        end
      end
    end
    if (out_done_i) begin
      pos_d = '0; depth_d = '0; ph_d = PhTag; tag_d = '0; len_d = '0; lbl_d = '0;
      cl_d = '0; oid_d = '0; armed_d = 1'b0; found_d = 1'b0; crop_d = 1'b0;
      err_d = StOk; cnt_d = '0; smp_d = 1'b0; lead_d = '0; take_d = '0;
    end
  end

  // status at end of stream
  logic [1:0] fin_st;
  always_comb begin
    if (err_q != StOk) fin_st = err_q;
    else if (ph_q != PhTag || depth_q != '0) fin_st = StInvalid;
    else fin_st = found_q ? StOk : StNotFound;
  end

  always_comb begin
    res_o = '0;
    res_o.cropped = crop_q;
    if (out_sel_i) begin
      res_o.kind = 1'b1; res_o.sidx = cnt_q; res_o.status = fin_st; res_o.fin = 1'b1;
    end else begin
      res_o.sbyte = sb_q; res_o.sidx = si_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) stack_q[AW'(depth_q)] <= push_val;
    sb_q <= sb_d;
    si_q <= si_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0; cap_q <= SampleCapReset; front_q <= 1'b0;
      pos_q <= '0; depth_q <= '0; ph_q <= PhTag; tag_q <= '0; len_q <= '0;
      lbl_q <= '0; cl_q <= '0; oid_q <= '0; armed_q <= 1'b0; found_q <= 1'b0;
      crop_q <= 1'b0; smp_q <= 1'b0; err_q <= StOk; cnt_q <= '0;
      lead_q <= '0; take_q <= '0; close_q <= 1'b0; hs_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegTargetOid:     target_q <= cfg_data_i;
          RegSampleCap:     cap_q    <= cfg_data_i[15:0];
          RegCropFromFront: front_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      pos_q <= pos_d; depth_q <= depth_d; ph_q <= ph_d; tag_q <= tag_d; len_q <= len_d;
      lbl_q <= lbl_d; cl_q <= cl_d; oid_q <= oid_d; armed_q <= armed_d; found_q <= found_d;
      crop_q <= crop_d; smp_q <= smp_d; err_q <= err_d; cnt_q <= cnt_d;
      lead_q <= lead_d; take_q <= take_d; close_q <= close_d; hs_q <= hs_d;
    end
  end

endmodule

>>> hdl/der_oid_value_extractor.sv
// Top level: DER OID value extractor, controller plus datapath.
//
//  channel  dir  handshake               payload
//  s_axis   in   s_axis_tvalid/tready    tdata=stream_byte, tlast=end_of_stream
//  m_axis   out  m_axis_tvalid/tready    tdata, tuser=result_kind, tlast=final_result
//  cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// Each byte gets a load and then a status check. A byte that completes an object
// or a sequence header adds a close check plus one more per sequence it closes.
// Each result transfer is held while m_axis_tready is low.
// Reset clears all control state; the stream restarts after the status result.
// The block holds off input until all results of a byte have been taken.
module der_oid_value_extractor
  import dox_pkg::*;
#(
  parameter int unsigned MaxNesting = MaxNestingDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] sample_byte, [23:8] sample_index,
                                      // [25:24] status, [26] was_cropped
  output logic        m_axis_tuser,   // [0] result_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  dox_cmd_t cmd;
  dox_sts_t sts;
  dox_res_t res;
  logic     sel;

  assign cfg_ready_o = 1'b1;

  dox_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_eos_i   (s_axis_tlast),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_sel_o  (sel),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dox_dp #(.MaxNesting(MaxNesting)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i  (cfg_valid_i),
    .cfg_idx_i (cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .byte_i    (s_axis_tdata),
    .eos_i     (s_axis_tlast),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_sel_i (sel),
    .out_done_i(m_axis_tvalid & m_axis_tready & sel),
    .res_o     (res)
  );

  assign m_axis_tdata = {5'd0, res.cropped, res.status, res.sidx, res.sbyte};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.fin;

endmodule
